// File: design/dtsm_pkg.sv
// ---------------------------------------------------------------------------
// dtsm_pkg
// Shared types and constants of the dense-times-sparse matrix multiplier.
// ---------------------------------------------------------------------------
package dtsm_pkg;

  localparam int DefMaxRows    = 64;
  localparam int DefMaxInner   = 64;
  localparam int DefMaxOutCols = 64;

  localparam int CmdW  = 2;
  localparam int IdxW  = 6;
  localparam int ValW  = 32;
  localparam int RowsW = 7;

  localparam logic [RowsW-1:0] RowsReset = 7'd64;

  typedef enum logic [CmdW-1:0] {
    CMD_WRITE = 2'd0,
    CMD_APPLY = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_APPLY,
    ST_READ
  } state_t;

endpackage

// File: design/dense_times_sparse_matmul.sv
// ---------------------------------------------------------------------------
// dense_times_sparse_matmul
// Dense matrix A times a sparse matrix streamed as nonzeros, in Q16.16, with
// the dense and output matrices held in two synchronous memories.
// ---------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ----------------------------------------------
//  in       start / busy         in_cmd, in_first_index, in_second_index,
//                                in_nz_value
//  out      out_strobe           out_read_value (one cycle, cannot be held)
//  cfg      cfg_valid/cfg_ready  cfg_dense_rows
//
//  Dense write: the entry is written at the accepting edge. Output read:
//  the result beat comes in the cycle after the accepting cycle.
//  Apply: one multiply-accumulate per row through the read, multiply and
//  write-back stages of the output memory.
//  Clear: one output entry per cycle; the clearing pass after reset runs
//  with busy high. The configuration port is always ready. Results cannot
//  be stalled.
//
module dense_times_sparse_matmul #(
  parameter int MAX_ROWS     = dtsm_pkg::DefMaxRows,
  parameter int MAX_INNER    = dtsm_pkg::DefMaxInner,
  parameter int MAX_OUT_COLS = dtsm_pkg::DefMaxOutCols
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [dtsm_pkg::CmdW-1:0]           in_cmd,
  input  logic [dtsm_pkg::IdxW-1:0]           in_first_index,
  input  logic [dtsm_pkg::IdxW-1:0]           in_second_index,
  input  logic signed [dtsm_pkg::ValW-1:0]    in_nz_value,
  output logic                                out_strobe,
  output logic signed [dtsm_pkg::ValW-1:0]    out_read_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtsm_pkg::RowsW-1:0]          cfg_dense_rows
);
  import dtsm_pkg::*;

  localparam int DepthD = MAX_ROWS * MAX_INNER;
  localparam int DepthO = MAX_ROWS * MAX_OUT_COLS;
  localparam int AwD    = (DepthD > 1) ? $clog2(DepthD) : 1;
  localparam int AwO    = (DepthO > 1) ? $clog2(DepthO) : 1;
  localparam int RowW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic signed [48:0] SatMax = 49'sd2147483647;
  localparam logic signed [48:0] SatMin = -49'sd2147483648;

  // Memories
  logic [ValW-1:0] dense_mem [DepthD];
  logic [ValW-1:0] out_mem   [DepthO];

  state_t state_r, state_nxt;

  logic [RowsW-1:0]       rows_r;
  logic [IdxW-1:0]        i_r;
  logic [IdxW-1:0]        j_r;
  logic signed [ValW-1:0] nz_r;
  logic                   rd_ok_r;
  logic [RowW-1:0]        k_r, last_r;
  logic                   issuing_r;
  logic                   v1_r, v2_r;
  logic [AwO-1:0]         wa1_r, wa2_r;
  logic [AwO-1:0]         clr_r;
  logic signed [63:0]     prod_r;
  logic signed [ValW-1:0] acc_r;
  logic [ValW-1:0]        dense_rdata_r;
  logic [ValW-1:0]        out_rdata_r;

  logic             accept;
  logic             clr_done;
  logic             apply_done;
  logic             apply_ok;
  logic             read_ok;
  logic             write_ok;
  logic [31:0]      rows_lim;
  logic [AwO-1:0]   in_out_addr;
  logic [AwD-1:0]   in_dense_addr;
  logic [AwO-1:0]   k_out_addr;
  logic [AwD-1:0]   k_dense_addr;
  logic signed [48:0] sum;
  logic [ValW-1:0]  sat_val;

  logic             dense_we;
  logic [AwD-1:0]   dense_waddr;
  logic [AwD-1:0]   dense_raddr;
  logic             out_we;
  logic [AwO-1:0]   out_waddr;
  logic [ValW-1:0]  out_wdata;
  logic [AwO-1:0]   out_raddr;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    rows_lim   = (32'(rows_r) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(rows_r);
    write_ok   = (32'(in_first_index) < 32'(MAX_ROWS)) &&
                 (32'(in_second_index) < 32'(MAX_INNER));
    read_ok    = (32'(in_first_index) < 32'(MAX_ROWS)) &&
                 (32'(in_second_index) < 32'(MAX_OUT_COLS));
    apply_ok   = (32'(in_first_index) < 32'(MAX_INNER)) &&
                 (32'(in_second_index) < 32'(MAX_OUT_COLS)) && (rows_lim != 32'd0);
    in_dense_addr = AwD'(32'(in_first_index) * 32'(MAX_INNER) + 32'(in_second_index));
    in_out_addr   = AwO'(32'(in_first_index) * 32'(MAX_OUT_COLS) + 32'(in_second_index));
    k_dense_addr  = AwD'(32'(k_r) * 32'(MAX_INNER) + 32'(i_r));
    k_out_addr    = AwO'(32'(k_r) * 32'(MAX_OUT_COLS) + 32'(j_r));
    clr_done   = (clr_r == AwO'(DepthO - 1));
    apply_done = !issuing_r && !v1_r && !v2_r;
  end

  // Truncating the product to Q16.16 is an arithmetic shift, which floors.
  always_comb begin
    sum = 49'(prod_r >>> 16) + 49'(acc_r);
    if (sum > SatMax) begin
      sat_val = 32'h7FFF_FFFF;
    end else if (sum < SatMin) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = sum[ValW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_APPLY: state_nxt = apply_ok ? ST_APPLY : ST_IDLE;
            CMD_READ:  state_nxt = ST_READ;
            CMD_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_APPLY: if (apply_done) state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    busy           = (state_r != ST_IDLE);
    out_strobe     = 1'b0;
    out_read_value = '0;
    dense_we       = 1'b0;
    dense_waddr    = in_dense_addr;
    dense_raddr    = k_dense_addr;
    out_we         = 1'b0;
    out_waddr      = wa2_r;
    out_wdata      = sat_val;
    out_raddr      = k_out_addr;
    case (state_r)
      ST_IDLE: begin
        dense_we  = accept && (cmd_t'(in_cmd) == CMD_WRITE) && write_ok;
        out_raddr = in_out_addr;
      end
      ST_CLEAR: begin
        out_we    = 1'b1;
        out_waddr = clr_r;
        out_wdata = '0;
      end
      ST_APPLY: begin
        out_we = v2_r;
      end
      ST_READ: begin
        out_strobe     = 1'b1;
        out_read_value = rd_ok_r ? signed'(out_rdata_r) : '0;
      end
      default: begin
        out_we = 1'b0;
      end
    endcase
  end

  // Dense matrix memory
  always_ff @(posedge clk) begin
    if (dense_we) begin
      dense_mem[dense_waddr] <= in_nz_value;
    end
    dense_rdata_r <= dense_mem[dense_raddr];
  end

  // Output matrix memory. Rows of one apply are distinct entries and applies
  // do not overlap, so a read never meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_waddr] <= out_wdata;
    end
    out_rdata_r <= out_mem[out_raddr];
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= signed'(dense_rdata_r) * nz_r;
    acc_r  <= signed'(out_rdata_r);
    wa2_r  <= wa1_r;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      rows_r    <= RowsReset;
      clr_r     <= '0;
      k_r       <= '0;
      last_r    <= '0;
      issuing_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        rows_r <= cfg_dense_rows;
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      v1_r <= (state_r == ST_APPLY) && issuing_r;
      v2_r <= v1_r;
      if ((state_r == ST_APPLY) && issuing_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == last_r) begin
          issuing_r <= 1'b0;
        end
      end
      if (accept) begin
        case (cmd_t'(in_cmd))
          CMD_APPLY: begin
            k_r       <= '0;
            last_r    <= RowW'(rows_lim - 32'd1);
            issuing_r <= apply_ok;
          end
          CMD_READ:  rd_ok_r <= read_ok;
          CMD_CLEAR: clr_r <= '0;
          default:   rd_ok_r <= rd_ok_r;
        endcase
      end
    end
  end

  // Payload captured with every accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      i_r  <= in_first_index;
      j_r  <= in_second_index;
      nz_r <= in_nz_value;
    end
    wa1_r <= k_out_addr;
  end

  // Assertions
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_READ)) |=> out_strobe)
    else $error("read beat not answered in the following cycle");

  a_pipe_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> (state_r == ST_APPLY))
    else $error("apply pipeline active outside an apply");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !out_we)
    else $error("output memory written while idle");

endmodule
